/* rtl/core/lz4d_pkg.sv */
// Package for the LZ4 block decompressor: beat types, decoder phases and constants.
// No dependencies; every other file of the block but lz4d_fifo imports it.
package lz4d_pkg;

  localparam int unsigned RunW = 17;
  localparam logic [RunW-1:0] RunMax = '1;
  localparam logic [3:0] NibbleExt = 4'hf;
  localparam logic [RunW-1:0] MinMatch = 17'd4;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrOffset = 2'd1;
  localparam logic [1:0] ErrTrunc = 2'd2;
  localparam logic [1:0] ErrLength = 2'd3;

  typedef enum logic [2:0] {
    PhToken, PhLitExt, PhLiteral, PhOffLo, PhOffHi, PhMatExt, PhCopy
  } lz4d_phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } lz4d_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       copy_pending;
    logic       rejected;
    logic       done_res;
    logic [1:0] error_code;
  } lz4d_out_t;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data_byte;
    logic       is_last;
    logic       byte_ff;
  } lz4d_cmd_t;

endpackage

/* rtl/core/lz4_block_decompressor.sv */
// Top level of the LZ4 block decompressor: front stage, command queue, back decoder, result queue.
// Depends on lz4d_pkg, lz4d_front, lz4d_fifo and lz4d_back.
//
//   Channel  Handshake     Payload
//   input    push / full   in_i  (mode, data_byte, last_byte)
//   result   empty / pop   out_o (out_byte, out_valid, copy_pending, rejected, done_res,
//                                 error_code)
//
// One beat is taken per cycle while full is low; each beat yields exactly one result, which
// passes the front register, the command queue, the decoder stage and the result queue.
// Each beat needs at most one history read and one history write, so the rate is one per cycle
// while the result queue has room. Reset is asynchronous and active low; the history memory is
// not cleared. A full result queue stalls the decoder, which in turn backs up the input side.
module lz4_block_decompressor import lz4d_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  lz4d_in_t  in_i,
  output logic      empty,
  input  logic      pop,
  output lz4d_out_t out_o
);
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 4;

  lz4d_cmd_t front_cmd, back_cmd;
  lz4d_out_t back_res;
  logic front_push, cmd_full, cmd_empty, cmd_pop, res_push, out_full;
  logic [$clog2(CmdDepth+1)-1:0] cmd_count;
  logic [$clog2(OutDepth+1)-1:0] out_count;

  lz4d_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_i,
    .q_full_i(cmd_full), .q_push_o(front_push), .cmd_o(front_cmd)
  );

  lz4d_fifo #(.WIDTH($bits(lz4d_cmd_t)), .DEPTH(CmdDepth)) u_cmd_q (
    .clk_i, .rst_ni, .wr_en_i(front_push), .wr_data_i(front_cmd), .rd_en_i(cmd_pop),
    .rd_data_o(back_cmd), .empty_o(cmd_empty), .full_o(cmd_full), .count_o(cmd_count)
  );

  lz4d_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .OUT_DEPTH(OutDepth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(!cmd_empty && cmd_count != '0), .cmd_i(back_cmd),
    .cmd_pop_o(cmd_pop), .out_count_i(out_count), .res_push_o(res_push), .res_o(back_res)
  );

  lz4d_fifo #(.WIDTH($bits(lz4d_out_t)), .DEPTH(OutDepth)) u_res_q (
    .clk_i, .rst_ni, .wr_en_i(res_push), .wr_data_i(back_res), .rd_en_i(pop && !empty),
    .rd_data_o(out_o), .empty_o(empty), .full_o(out_full), .count_o(out_count)
  );
endmodule

/* rtl/core/lz4d_fifo.sv */
// Small register queue used between the decoder parts and at the result side.
// Depends on nothing; width and depth come from parameters.
module lz4d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [WIDTH-1:0]           wr_data_i,
  input  logic                       rd_en_i,
  output logic [WIDTH-1:0]           rd_data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = wr_en_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d = count_q + CntW'(wr_en_i) - CntW'(rd_en_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = entry_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o = (count_q == CntW'(DEPTH));
  assign count_o = count_q;
endmodule

/* rtl/core/lz4d_front.sv */
// Front part: registers input beats and classifies them into decoder commands.
// Depends on lz4d_pkg.
module lz4d_front import lz4d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  lz4d_in_t  in_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output lz4d_cmd_t cmd_o
);
  logic valid_q, valid_d;
  lz4d_cmd_t cmd_q, cmd_d;
  logic take;

  assign q_push_o = valid_q && !q_full_i;
  assign full = valid_q && q_full_i;
  assign take = push && !full;

  always_comb begin
    valid_d = take || (valid_q && q_full_i);
    cmd_d = cmd_q;
    if (take) begin
      cmd_d.is_tick = in_i.mode;
      cmd_d.data_byte = in_i.data_byte;
      cmd_d.is_last = in_i.last_byte;
      cmd_d.byte_ff = (in_i.data_byte == 8'hff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_o = cmd_q;
endmodule

/* rtl/core/lz4d_back.sv */
// Back part: runs the LZ4 sequence decoder, owns the history memory and forms results.
// Depends on lz4d_pkg.
module lz4d_back import lz4d_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  lz4d_cmd_t                      cmd_i,
  output logic                           cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                           res_push_o,
  output lz4d_out_t                      res_o
);
  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW = $clog2(OUT_DEPTH + 1);
  localparam logic [RunW-1:0] DepthW = RunW'(HISTORY_DEPTH);

  logic [7:0] mem [HISTORY_DEPTH];

  lz4d_phase_e phase_q, phase_d;
  logic [3:0] nib_q, nib_d;
  logic [RunW-1:0] run_q, run_d;
  logic [15:0] dist_q, dist_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [RunW-1:0] prod_q, prod_d;

  logic s2_valid_q, s2_copy_q, s2_fwd_q, s2_wr_q;
  logic [AddrW-1:0] s2_addr_q;
  lz4d_out_t s2_res_q;
  logic [7:0] rd_data_q, fwd_data_q, s2_byte;

  logic fire, wr_en, do_copy, fwd;
  logic [AddrW-1:0] rd_addr;
  logic [RunW:0] ext_sum, mat_sum;
  logic [RunW-1:0] wp_ext, full_dist, rl_dec;
  lz4d_out_t res;

  assign fire = cmd_valid_i && ((out_count_i + CntW'(s2_valid_q)) < CntW'(OUT_DEPTH));
  assign cmd_pop_o = fire;
  assign do_copy = cmd_i.is_tick && (phase_q == PhCopy);
  assign ext_sum = {1'b0, run_q} + (RunW + 1)'(cmd_i.data_byte);
  assign mat_sum = ext_sum + (RunW + 1)'(MinMatch);
  assign wp_ext = RunW'(wp_q);
  assign full_dist = {{(RunW - 16){1'b0}}, dist_q};
  assign rl_dec = (run_q != '0) ? run_q - 1'b1 : run_q;
  assign rd_addr = (wp_ext >= full_dist) ? AddrW'(wp_ext - full_dist)
                                         : AddrW'(wp_ext + DepthW - full_dist);
  assign fwd = s2_valid_q && s2_wr_q && (s2_addr_q == rd_addr);

  // Next decoder state.
  always_comb begin
    logic [15:0] dist_new;
    logic end_blk;
    dist_new = {cmd_i.data_byte, dist_q[7:0]};
    phase_d = phase_q;
    nib_d = nib_q;
    run_d = run_q;
    dist_d = dist_q;
    wp_d = wp_q;
    prod_d = prod_q;
    end_blk = 1'b0;
    if (cmd_i.is_tick) begin
      if (do_copy) begin
        run_d = rl_dec;
        if (rl_dec == '0) begin
          phase_d = PhToken;
        end
      end
    end else if (phase_q != PhCopy) begin
      case (phase_q)
        PhToken: begin
          nib_d = cmd_i.data_byte[3:0];
          run_d = RunW'(cmd_i.data_byte[7:4]);
          if (cmd_i.is_last) begin
            end_blk = 1'b1;
          end else if (cmd_i.data_byte[7:4] == NibbleExt) begin
            phase_d = PhLitExt;
          end else if (cmd_i.data_byte[7:4] != 4'd0) begin
            phase_d = PhLiteral;
          end else begin
            phase_d = PhOffLo;
          end
        end
        PhLitExt: begin
          if (ext_sum > {1'b0, RunMax} || cmd_i.is_last) begin
            end_blk = 1'b1;
          end else begin
            run_d = ext_sum[RunW-1:0];
            if (!cmd_i.byte_ff) begin
              phase_d = PhLiteral;
            end
          end
        end
        PhLiteral: begin
          run_d = rl_dec;
          if (rl_dec == '0 && !cmd_i.is_last) begin
            phase_d = PhOffLo;
          end
          if (cmd_i.is_last) begin
            end_blk = 1'b1;
          end
        end
        PhOffLo: begin
          dist_d = {8'd0, cmd_i.data_byte};
          if (cmd_i.is_last) begin
            end_blk = 1'b1;
          end else begin
            phase_d = PhOffHi;
          end
        end
        PhOffHi: begin
          dist_d = dist_new;
          if (dist_new == '0 || {1'b0, dist_new} > DepthW || {1'b0, dist_new} > prod_q
              || cmd_i.is_last) begin
            end_blk = 1'b1;
          end else if (nib_q == NibbleExt) begin
            run_d = RunW'(NibbleExt);
            phase_d = PhMatExt;
          end else begin
            run_d = RunW'(nib_q) + MinMatch;
            phase_d = PhCopy;
          end
        end
        PhMatExt: begin
          if (ext_sum > {1'b0, RunMax} || cmd_i.is_last) begin
            end_blk = 1'b1;
          end else if (cmd_i.byte_ff) begin
            run_d = ext_sum[RunW-1:0];
          end else if (mat_sum > {1'b0, RunMax}) begin
            end_blk = 1'b1;
          end else begin
            run_d = mat_sum[RunW-1:0];
            phase_d = PhCopy;
          end
        end
        default: begin
          phase_d = PhToken;
        end
      endcase
    end
    if (wr_en) begin
      wp_d = (wp_q == AddrW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (prod_q != RunMax) begin
        prod_d = prod_q + 1'b1;
      end
    end
    if (end_blk) begin
      phase_d = PhToken;
      run_d = '0;
      wp_d = '0;
      prod_d = '0;
    end
  end

  // Result flags and history write enable.
  always_comb begin
    logic [15:0] dist_new;
    dist_new = {cmd_i.data_byte, dist_q[7:0]};
    res = '0;
    wr_en = 1'b0;
    if (cmd_i.is_tick) begin
      if (do_copy) begin
        res.out_valid = 1'b1;
        wr_en = 1'b1;
      end
    end else if (phase_q == PhCopy) begin
      res.rejected = 1'b1;
    end else begin
      case (phase_q)
        PhToken: begin
          if (cmd_i.is_last) begin
            if (cmd_i.data_byte[7:4] == 4'd0) begin
              res.done_res = 1'b1;
            end else begin
              res.error_code = ErrTrunc;
            end
          end
        end
        PhLitExt: begin
          if (ext_sum > {1'b0, RunMax}) begin
            res.error_code = ErrLength;
          end else if (cmd_i.is_last) begin
            res.error_code = ErrTrunc;
          end
        end
        PhLiteral: begin
          res.out_byte = cmd_i.data_byte;
          res.out_valid = 1'b1;
          wr_en = 1'b1;
          if (cmd_i.is_last) begin
            if (rl_dec == '0) begin
              res.done_res = 1'b1;
            end else begin
              res.error_code = ErrTrunc;
            end
          end
        end
        PhOffLo: begin
          if (cmd_i.is_last) begin
            res.error_code = ErrTrunc;
          end
        end
        PhOffHi: begin
          if (dist_new == '0 || {1'b0, dist_new} > DepthW || {1'b0, dist_new} > prod_q) begin
            res.error_code = ErrOffset;
          end else if (cmd_i.is_last) begin
            res.error_code = ErrTrunc;
          end
        end
        PhMatExt: begin
          if (ext_sum > {1'b0, RunMax}) begin
            res.error_code = ErrLength;
          end else if (cmd_i.is_last) begin
            res.error_code = ErrTrunc;
          end else if (!cmd_i.byte_ff && mat_sum > {1'b0, RunMax}) begin
            res.error_code = ErrLength;
          end
        end
        default: begin
          res.error_code = ErrNone;
        end
      endcase
    end
    res.copy_pending = (phase_d == PhCopy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhToken;
      nib_q <= '0;
      run_q <= '0;
      dist_q <= '0;
      wp_q <= '0;
      prod_q <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= fire;
      if (fire) begin
        phase_q <= phase_d;
        nib_q <= nib_d;
        run_q <= run_d;
        dist_q <= dist_d;
        wp_q <= wp_d;
        prod_q <= prod_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_res_q <= res;
    s2_copy_q <= do_copy;
    s2_wr_q <= fire && wr_en;
    s2_addr_q <= wp_q;
    s2_fwd_q <= fwd;
    fwd_data_q <= s2_byte;
    if (fire && do_copy) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    if (s2_copy_q) begin
      s2_byte = s2_fwd_q ? fwd_data_q : rd_data_q;
    end else begin
      s2_byte = s2_res_q.out_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_wr_q) begin
      mem[s2_addr_q] <= s2_byte;
    end
  end

  always_comb begin
    res_o = s2_res_q;
    res_o.out_byte = s2_byte;
  end

  assign res_push_o = s2_valid_q;
endmodule

/* rtl/core/lz4d_checker.sv */
// Port-level checks for the LZ4 block decompressor, bound to the top level.
// Depends on lz4d_pkg.
module lz4d_checker import lz4d_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input lz4d_out_t out_o
);
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.out_valid) |-> (out_o.out_byte == 8'd0)) else $error("byte without valid");
  a_done_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.done_res) |-> (out_o.error_code == ErrNone)) else $error("done with error");
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.rejected) |-> (out_o.copy_pending && !out_o.out_valid))
    else $error("bad reject");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o))) else $error("result dropped");
endmodule

bind lz4_block_decompressor lz4d_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_o
);

/* verif/tb.sv */
// Testbench for lz4_block_decompressor: directed table, then random LZ4 blocks and noise.
// Depends on lz4d_pkg and the block's RTL; results are checked vs typed rows or in-bench decoder.
module tb;
  import lz4d_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandBeats = 650;

  typedef struct packed {
    lz4d_in_t  beat;
    logic      typed;
    lz4d_out_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  lz4d_in_t  in_i;
  logic      empty;
  logic      pop;
  lz4d_out_t out_o;

  lz4_block_decompressor dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .out_o(out_o)
  );

  lz4d_phase_e  dec_phase;
  logic [3:0]   dec_match_nib;
  int unsigned  dec_run;
  logic [15:0]  dec_dist;
  logic [15:0]  dec_wpos;
  int unsigned  dec_produced;
  logic [7:0]   dec_hist [65536];

  lz4d_out_t    want_q [$];
  lz4d_in_t     plan_q [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  results = 0;
  int unsigned  beats_sent = 0;
  int unsigned  send_steady = 0;
  int unsigned  recv_steady = 0;

  dir_row_t dir_tab [25] = '{
    '{'{1'b1, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ErrNone}},
    '{'{1'b0, 8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ErrNone}},
    '{'{1'b0, 8'h10, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ErrTrunc}},
    '{'{1'b0, 8'h20, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'hAA, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h55, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ErrOffset}},
    '{'{1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h01, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ErrOffset}},
    '{'{1'b0, 8'h10, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h01, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h77, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b1, 8'hFF, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ErrNone}},
    '{'{1'b0, 8'hF0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ErrTrunc}},
    '{'{1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h05, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ErrTrunc}}
  };

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(ref int unsigned steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady > 0) begin
      steady--;
      return 0;
    end
    if (r < 3) begin
      steady = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic store_out(input logic [7:0] b);
    dec_hist[dec_wpos] = b;
    dec_wpos = dec_wpos + 16'd1;
    if (dec_produced < RunMax) dec_produced++;
  endtask

  task automatic new_block();
    dec_phase = PhToken;
    dec_run = 0;
    dec_wpos = '0;
    dec_produced = 0;
  endtask

  task automatic decode_beat(input lz4d_in_t b, output lz4d_out_t r);
    logic [3:0] lit;
    r = '0;
    r.error_code = ErrNone;
    if (b.mode) begin
      if (dec_phase == PhCopy) begin
        r.out_byte = dec_hist[dec_wpos - dec_dist];
        r.out_valid = 1'b1;
        store_out(r.out_byte);
        if (dec_run > 0) dec_run--;
        if (dec_run == 0) dec_phase = PhToken;
      end
    end else if (dec_phase == PhCopy) begin
      r.rejected = 1'b1;
    end else begin
      case (dec_phase)
        PhToken: begin
          lit = b.data_byte[7:4];
          dec_match_nib = b.data_byte[3:0];
          dec_run = lit;
          if (b.last_byte) begin
            if (lit == 0) r.done_res = 1'b1;
            else r.error_code = ErrTrunc;
          end else if (lit == NibbleExt) dec_phase = PhLitExt;
          else if (lit != 0) dec_phase = PhLiteral;
          else dec_phase = PhOffLo;
        end
        PhLitExt: begin
          if (dec_run + b.data_byte > RunMax) r.error_code = ErrLength;
          else begin
            dec_run += b.data_byte;
            if (b.last_byte) r.error_code = ErrTrunc;
            else if (b.data_byte != 8'hFF) dec_phase = PhLiteral;
          end
        end
        PhLiteral: begin
          r.out_byte = b.data_byte;
          r.out_valid = 1'b1;
          store_out(b.data_byte);
          if (dec_run > 0) dec_run--;
          if (dec_run == 0) begin
            if (b.last_byte) r.done_res = 1'b1;
            else dec_phase = PhOffLo;
          end else if (b.last_byte) r.error_code = ErrTrunc;
        end
        PhOffLo: begin
          dec_dist[7:0] = b.data_byte;
          if (b.last_byte) r.error_code = ErrTrunc;
          else dec_phase = PhOffHi;
        end
        PhOffHi: begin
          dec_dist[15:8] = b.data_byte;
          if (dec_dist == 0 || dec_dist > dec_produced) r.error_code = ErrOffset;
          else if (b.last_byte) r.error_code = ErrTrunc;
          else if (dec_match_nib == NibbleExt) begin
            dec_run = NibbleExt;
            dec_phase = PhMatExt;
          end else begin
            dec_run = dec_match_nib + MinMatch;
            dec_phase = PhCopy;
          end
        end
        PhMatExt: begin
          if (dec_run + b.data_byte > RunMax) r.error_code = ErrLength;
          else begin
            dec_run += b.data_byte;
            if (b.last_byte) r.error_code = ErrTrunc;
            else if (b.data_byte != 8'hFF) begin
              if (dec_run + MinMatch > RunMax) r.error_code = ErrLength;
              else begin
                dec_run += MinMatch;
                dec_phase = PhCopy;
              end
            end
          end
        end
        default: dec_phase = PhToken;
      endcase
      if (r.done_res || r.error_code != ErrNone) new_block();
    end
    r.copy_pending = (dec_phase == PhCopy);
  endtask

  // Offers one beat and records its expectation when the block takes it.
  task automatic send_beat(input lz4d_in_t b, input logic typed, input lz4d_out_t want);
    int unsigned gap;
    lz4d_out_t r;
    gap = pick_gap(send_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_beat(b, r);
    want_q.push_back(typed ? want : r);
    beats_sent++;
  endtask

  task automatic send_plan();
    while (plan_q.size() > 0) send_beat(plan_q.pop_front(), 1'b0, '0);
  endtask

  function automatic lz4d_in_t mk(input logic m, input logic [7:0] d, input logic l);
    lz4d_in_t b;
    b.mode = m;
    b.data_byte = d;
    b.last_byte = l;
    return b;
  endfunction

  // Builds one well-formed block into the plan, with random content and stray beats in copies.
  task automatic plan_block();
    int unsigned nseq;
    int unsigned lit;
    int unsigned mlen;
    int unsigned produced;
    int unsigned rem;
    int unsigned offs;
    logic [3:0] mnib;
    logic fin;
    produced = 0;
    nseq = $urandom_range(1, 4);
    for (int s = 0; s < nseq; s++) begin
      fin = (s == nseq - 1);
      if ($urandom_range(0, 9) == 0) lit = $urandom_range(15, 300);
      else lit = $urandom_range(fin ? 0 : 1, 10);
      mnib = 4'($urandom_range(0, 15));
      plan_q.push_back(mk(1'b0, {(lit >= 15) ? 4'hF : lit[3:0], mnib}, fin && lit == 0));
      if (lit >= 15) begin
        rem = lit - 15;
        while (rem >= 255) begin
          plan_q.push_back(mk(1'b0, 8'hFF, 1'b0));
          rem -= 255;
        end
        plan_q.push_back(mk(1'b0, rem[7:0], 1'b0));
      end
      for (int i = 0; i < lit; i++)
        plan_q.push_back(mk(1'b0, 8'($urandom_range(0, 255)), fin && i == lit - 1));
      produced += lit;
      if (fin) break;
      offs = $urandom_range(1, produced);
      plan_q.push_back(mk(1'b0, offs[7:0], 1'b0));
      plan_q.push_back(mk(1'b0, offs[15:8], 1'b0));
      mlen = mnib + 4;
      if (mnib == 4'hF) begin
        rem = ($urandom_range(0, 4) == 0) ? 255 + $urandom_range(0, 20) : $urandom_range(0, 20);
        mlen += rem;
        while (rem >= 255) begin
          plan_q.push_back(mk(1'b0, 8'hFF, 1'b0));
          rem -= 255;
        end
        plan_q.push_back(mk(1'b0, rem[7:0], 1'b0));
      end
      for (int i = 0; i < mlen; i++) begin
        if ($urandom_range(0, 15) == 0)
          plan_q.push_back(mk(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        plan_q.push_back(mk(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
      produced += mlen;
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned idx;
    rst_ni = 1'b0;
    push = 1'b0;
    in_i = '0;
    dec_match_nib = '0;
    dec_dist = '0;
    new_block();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

    // Literal length that runs past 17 bits.
    plan_q.push_back(mk(1'b0, 8'hF0, 1'b0));
    repeat (514) plan_q.push_back(mk(1'b0, 8'hFF, 1'b0));
    send_plan();
    // Match length that only overflows once the minimum match is added.
    plan_q.push_back(mk(1'b0, 8'h1F, 1'b0));
    plan_q.push_back(mk(1'b0, 8'h3C, 1'b0));
    plan_q.push_back(mk(1'b0, 8'h01, 1'b0));
    plan_q.push_back(mk(1'b0, 8'h00, 1'b0));
    repeat (513) plan_q.push_back(mk(1'b0, 8'hFF, 1'b0));
    plan_q.push_back(mk(1'b0, 8'hF1, 1'b0));
    send_plan();

    beats_sent = 0;
    while (beats_sent < RandBeats) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 6))
          plan_q.push_back(mk(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0));
      end else begin
        plan_block();
        if (r < 22) begin
          // Cut the block short with an early final byte.
          idx = $urandom_range(0, plan_q.size() - 1);
          plan_q[idx].last_byte = 1'b1;
          while (plan_q.size() > idx + 1) void'(plan_q.pop_back());
        end else if (r < 27) begin
          plan_q = '{mk(1'b0, 8'h30, 1'b0), mk(1'b0, 8'h11, 1'b0), mk(1'b0, 8'h22, 1'b0),
                     mk(1'b0, 8'h33, 1'b0), mk(1'b0, 8'($urandom_range(3, 255)), 1'b0),
                     mk(1'b0, 8'($urandom_range(0, 255)), 1'b0)};
        end
      end
      send_plan();
    end
    push <= 1'b0;

    while (want_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp);
    $display("tb: result %0d %s got %0h want %0h", results, what, got, exp);
    errors++;
  endtask

  initial begin
    int unsigned gap;
    lz4d_out_t w;
    bit held;
    pop = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap(recv_steady);
      if (!held && results == 200) begin
        held = 1'b1;
        gap = 400;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      results++;
      if (want_q.size() == 0) begin
        $display("tb: unexpected result beat %0h", out_o);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (out_o.out_byte !== w.out_byte) report("out_byte", out_o.out_byte, w.out_byte);
        if (out_o.out_valid !== w.out_valid) report("out_valid", out_o.out_valid, w.out_valid);
        if (out_o.copy_pending !== w.copy_pending)
          report("copy_pending", out_o.copy_pending, w.copy_pending);
        if (out_o.rejected !== w.rejected) report("rejected", out_o.rejected, w.rejected);
        if (out_o.done_res !== w.done_res) report("done_res", out_o.done_res, w.done_res);
        if (out_o.error_code !== w.error_code)
          report("error_code", out_o.error_code, w.error_code);
      end
    end
  end

endmodule
